### rtl/deadline_task_table_core_defines.svh
// Assertion macros for the deadline task table.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef DEADLINE_TASK_TABLE_CORE_DEFINES_SVH
`define DEADLINE_TASK_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadline_task_table_core: assertion failed");

// Next-cycle implication.
`define DTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadline_task_table_core: assertion failed");

`else

`define DTT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dtt_pkg.sv
`timescale 1ns / 1ps

package dtt_pkg;

    localparam int ID_W        = 6;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 32;
    localparam int RES_IW      = 5;   // index into the fired-id list
    localparam int RES_CW      = 6;   // count of fired ids, 0..MAX_RESULTS

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ONESHOT  = 2'd1,
        KIND_PERIODIC = 2'd2,
        KIND_REMOVE   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TIME_W-1:0]  time_value;
        logic [ID_W-1:0]    slot_id;
    } t_in_item;

    typedef struct packed {
        t_kind              done_kind;
        logic [ID_W-1:0]    task_id;
        logic               fired;
        logic               next_valid;
        logic [TIME_W-1:0]  next_deadline;
        logic               last;
    } t_out_item;

endpackage

### rtl/deadline_task_table_core.sv
`timescale 1ns / 1ps

// Deadline task table: TASK_SLOTS timed tasks against a 32-bit microsecond
// counter. Each input transfer is one command: tick (advance time by one and
// fire every due slot in slot order), add one-shot (absolute deadline), add
// periodic (period, first deadline = now + period) or remove (1-based id).
// Adds take the lowest free slot and answer its id, or 0 when the table is
// full. Every command answers with one or more output transfers, all carrying
// the earliest deadline strictly after now (the compare value) and its valid
// flag; last marks the final transfer of a command. A tick answers one
// transfer per fired slot (at most 32 are reported, further slots still
// fire), or a single transfer with task_id 0 when nothing fired.
// Timing: one command at a time. The command rate is set by the single read
// port of the deadline and period memories: a tick makes one pass over all
// slots to fire, then every command makes one pass to find the next deadline
// and the lowest free slot, one slot per cycle through one shared adder and
// shared comparators. Add and remove skip the fire pass.
// o_in_stall is high from accept until the last result is loaded into the
// output register, which holds it while i_out_stall is high.

`include "deadline_task_table_core_defines.svh"

module deadline_task_table_core #(
    parameter int TASK_SLOTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dtt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtt_pkg::t_out_item  o_out_data
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;   // slot index
    localparam int CW = $clog2(TASK_SLOTS + 1);                       // scan counter

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRE,
        ST_RESCAN,
        ST_EMIT
    } t_state;

    t_state                         r_state;
    logic [dtt_pkg::TIME_W-1:0]     r_now;
    logic [TASK_SLOTS-1:0]          r_active;

    // per-slot storage, one write and one registered read port
    logic [dtt_pkg::TIME_W-1:0]     r_mem_dl  [TASK_SLOTS];
    logic [dtt_pkg::TIME_W-1:0]     r_mem_per [TASK_SLOTS];
    logic [dtt_pkg::TIME_W-1:0]     r_rd_dl;
    logic [dtt_pkg::TIME_W-1:0]     r_rd_per;

    // scan pipeline: address issue, then one processing stage
    logic [CW-1:0]                  r_cnt;
    logic                           r_p_vld;
    logic [IW-1:0]                  r_p_idx;

    // rescan results
    logic                           r_nv;
    logic [dtt_pkg::TIME_W-1:0]     r_best;
    logic                           r_free_ok;
    logic [IW-1:0]                  r_free_idx;

    // fired ids of the current tick
    logic [dtt_pkg::ID_W-1:0]       r_fire_ids [dtt_pkg::MAX_RESULTS];
    logic [dtt_pkg::RES_CW-1:0]     r_n;
    logic [dtt_pkg::RES_CW-1:0]     r_e;

    dtt_pkg::t_kind                 r_kind;
    logic [dtt_pkg::ID_W-1:0]       r_res_id;

    logic                           r_out_vld;
    dtt_pkg::t_out_item             r_out;

    logic                           w_in_acc;
    logic                           w_scan;
    logic                           w_issue;
    logic [IW-1:0]                  w_rd_addr;
    logic                           w_p_last;
    logic [dtt_pkg::TIME_W-1:0]     w_add_a;
    logic [dtt_pkg::TIME_W-1:0]     w_add_b;
    logic [dtt_pkg::TIME_W-1:0]     w_sum;
    logic                           w_gt_now;
    logic                           w_lt_best;
    logic                           w_fire;
    logic                           w_add_wr;
    logic                           w_we_dl;
    logic [IW-1:0]                  w_wa;
    logic [dtt_pkg::TIME_W-1:0]     w_wd_dl;
    logic [dtt_pkg::TIME_W-1:0]     w_wd_per;
    logic                           w_fifo_we;
    logic [dtt_pkg::ID_W:0]         w_p_id_f;
    logic [dtt_pkg::ID_W:0]         w_free_id_f;
    logic [dtt_pkg::ID_W-1:0]       w_sid_m1;
    logic [IW-1:0]                  w_rm_idx;
    logic                           w_rm_ok;
    logic [dtt_pkg::RES_CW-1:0]     w_total;
    logic                           w_out_free;
    dtt_pkg::t_out_item             w_out_next;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // scan addressing
    assign w_scan    = (r_state == ST_FIRE) || (r_state == ST_RESCAN);
    assign w_issue   = w_scan && (r_cnt < CW'(TASK_SLOTS));
    assign w_rd_addr = w_issue ? r_cnt[IW-1:0] : '0;
    assign w_p_last  = r_p_vld && (r_p_idx == IW'(TASK_SLOTS - 1));

    // shared adder: tick increment, now + period on add, rearm in fire pass
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_add_a = r_now;
            w_add_b = (i_in_data.kind == dtt_pkg::KIND_TICK) ? dtt_pkg::TIME_W'(1)
                                                              : i_in_data.time_value;
        end else begin
            w_add_a = r_rd_dl;
            w_add_b = r_rd_per;
        end
    end
    assign w_sum = w_add_a + w_add_b;

    // shared comparator
    assign w_gt_now  = r_rd_dl > r_now;
    assign w_lt_best = r_rd_dl < r_best;
    assign w_fire    = r_active[r_p_idx] && !w_gt_now;

    // memory write port: add in idle, rearm of a fired periodic slot
    assign w_add_wr = (r_state == ST_IDLE) && w_in_acc && r_free_ok
                      && ((i_in_data.kind == dtt_pkg::KIND_ONESHOT)
                          || (i_in_data.kind == dtt_pkg::KIND_PERIODIC));
    assign w_we_dl  = w_add_wr
                      || ((r_state == ST_FIRE) && r_p_vld && w_fire && (r_rd_per != '0));
    assign w_wa     = (r_state == ST_IDLE) ? r_free_idx : r_p_idx;
    assign w_wd_dl  = ((r_state == ST_IDLE) && (i_in_data.kind == dtt_pkg::KIND_ONESHOT))
                      ? i_in_data.time_value : w_sum;
    assign w_wd_per = (i_in_data.kind == dtt_pkg::KIND_ONESHOT) ? '0 : i_in_data.time_value;

    assign w_fifo_we = (r_state == ST_FIRE) && r_p_vld && w_fire
                       && (r_n < dtt_pkg::RES_CW'(dtt_pkg::MAX_RESULTS));

    // 1-based ids; truncated to the id field width
    assign w_p_id_f    = (dtt_pkg::ID_W + 1)'(r_p_idx) + (dtt_pkg::ID_W + 1)'(1);
    assign w_free_id_f = (dtt_pkg::ID_W + 1)'(r_free_idx) + (dtt_pkg::ID_W + 1)'(1);

    // remove: ids 1..TASK_SLOTS only
    assign w_sid_m1 = i_in_data.slot_id - dtt_pkg::ID_W'(1);
    assign w_rm_idx = w_sid_m1[IW-1:0];
    assign w_rm_ok  = (i_in_data.slot_id != '0)
                      && ({1'b0, i_in_data.slot_id} <= (dtt_pkg::ID_W + 1)'(TASK_SLOTS));

    // result formatting
    assign w_total = ((r_kind == dtt_pkg::KIND_TICK) && (r_n != '0))
                     ? r_n : dtt_pkg::RES_CW'(1);
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        w_out_next.done_kind = r_kind;
        if (r_kind == dtt_pkg::KIND_TICK) begin
            w_out_next.task_id = (r_n == '0) ? '0 : r_fire_ids[r_e[dtt_pkg::RES_IW-1:0]];
        end else begin
            w_out_next.task_id = r_res_id;
        end
        w_out_next.fired         = (r_kind == dtt_pkg::KIND_TICK) && (r_n != '0);
        w_out_next.next_valid    = r_nv;
        w_out_next.next_deadline = r_nv ? r_best : '0;
        w_out_next.last          = ((r_e + dtt_pkg::RES_CW'(1)) == w_total);
    end

    // storage: slot memories and the fired-id list
    always_ff @(posedge i_clk) begin
        if (w_we_dl) begin
            r_mem_dl[w_wa] <= w_wd_dl;
        end
        if (w_add_wr) begin
            r_mem_per[w_wa] <= w_wd_per;
        end
        r_rd_dl  <= r_mem_dl[w_rd_addr];
        r_rd_per <= r_mem_per[w_rd_addr];
        if (w_fifo_we) begin
            r_fire_ids[r_n[dtt_pkg::RES_IW-1:0]] <= w_p_id_f[dtt_pkg::ID_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_now      <= '0;
            r_active   <= '0;
            r_cnt      <= '0;
            r_p_vld    <= 1'b0;
            r_p_idx    <= '0;
            r_nv       <= 1'b0;
            r_best     <= '0;
            r_free_ok  <= 1'b1;
            r_free_idx <= '0;
            r_n        <= '0;
            r_e        <= '0;
            r_kind     <= dtt_pkg::KIND_TICK;
            r_res_id   <= '0;
            r_out_vld  <= 1'b0;
            r_out      <= '0;
        end else begin
            // in ST_EMIT the output register is reloaded below
            if (r_out_vld && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_vld <= 1'b0;
            end

            // one slot address per cycle during either pass
            if (w_scan) begin
                if (w_issue) begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_p_vld <= 1'b1;
                    r_p_idx <= r_cnt[IW-1:0];
                end else begin
                    r_p_vld <= 1'b0;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_kind   <= i_in_data.kind;
                        r_res_id <= '0;
                        r_cnt    <= '0;
                        r_p_vld  <= 1'b0;
                        case (i_in_data.kind)
                            dtt_pkg::KIND_TICK: begin
                                r_now   <= w_sum;
                                r_n     <= '0;
                                r_state <= ST_FIRE;
                            end
                            dtt_pkg::KIND_ONESHOT, dtt_pkg::KIND_PERIODIC: begin
                                if (r_free_ok) begin
                                    r_active[r_free_idx] <= 1'b1;
                                    r_res_id <= w_free_id_f[dtt_pkg::ID_W-1:0];
                                end
                                r_nv      <= 1'b0;
                                r_free_ok <= 1'b0;
                                r_state   <= ST_RESCAN;
                            end
                            dtt_pkg::KIND_REMOVE: begin
                                if (w_rm_ok) begin
                                    r_active[w_rm_idx] <= 1'b0;
                                end
                                r_nv      <= 1'b0;
                                r_free_ok <= 1'b0;
                                r_state   <= ST_RESCAN;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FIRE: begin
                    // due slot: periodic rearms through the write port, one-shot frees
                    if (r_p_vld && w_fire) begin
                        if (r_rd_per == '0) begin
                            r_active[r_p_idx] <= 1'b0;
                        end
                        if (w_fifo_we) begin
                            r_n <= r_n + dtt_pkg::RES_CW'(1);
                        end
                    end
                    // the scan stage already drops r_p_vld on the last slot
                    if (w_p_last) begin
                        r_cnt     <= '0;
                        r_nv      <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= ST_RESCAN;
                    end
                end
                ST_RESCAN: begin
                    // earliest deadline after now, and the lowest free slot
                    if (r_p_vld) begin
                        if (r_active[r_p_idx]) begin
                            if (w_gt_now && (!r_nv || w_lt_best)) begin
                                r_nv   <= 1'b1;
                                r_best <= r_rd_dl;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_p_idx;
                        end
                    end
                    if (w_p_last) begin
                        r_e     <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= w_out_next;
                        if (w_out_next.last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_e <= r_e + dtt_pkg::RES_CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted command leaves the block busy in the cycle after the accept
    `DTT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_in_stall)
    // only tick results report a firing
    `DTT_ASSERT_IMPL(a_fired_only_on_tick, i_clk, i_rst_n, o_out_valid && o_out_data.fired, o_out_data.done_kind == dtt_pkg::KIND_TICK)
    // the fired-id list never overflows
    `DTT_ASSERT_IMPL(a_fire_list_bound, i_clk, i_rst_n, r_state == ST_EMIT, r_n <= dtt_pkg::RES_CW'(dtt_pkg::MAX_RESULTS))
    // compare value reads zero whenever it is not valid
    `DTT_ASSERT_IMPL(a_deadline_zero_when_invalid, i_clk, i_rst_n, o_out_valid && !o_out_data.next_valid, o_out_data.next_deadline == '0)

endmodule
